>>> rtl/speck32_block_cipher_assert.svh
// ----------------------------------------------------------------------------
// Speck32 assertion macros
// Concurrent assertion helpers for the Speck32 block cipher RTL.
// ----------------------------------------------------------------------------
`ifndef SPECK32_BLOCK_CIPHER_ASSERT_SVH
`define SPECK32_BLOCK_CIPHER_ASSERT_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define ASSERT_IMPLY(lbl, clk, rst_n, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("assertion failed");
// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst_n, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("assertion failed");
`else
`define ASSERT_IMPLY(lbl, clk, rst_n, a, b)
`define ASSERT_NEXT(lbl, clk, rst_n, a, b)
`endif

`endif

>>> rtl/spk_pkg.sv
// ----------------------------------------------------------------------------
// spk_pkg
// Shared types, constants and rotate helpers of the Speck32 block cipher.
// ----------------------------------------------------------------------------
package spk_pkg;

	localparam int SPK_MAX_ROUNDS     = 32;
	localparam int SPK_DEFAULT_ROUNDS = 22;
	localparam int SPK_WORD_W         = 16;
	localparam int SPK_CFG_IDX_W      = 3;
	localparam int SPK_KEY_WORDS      = 4;

	localparam logic [SPK_CFG_IDX_W-1:0] REG_KEY_WORD0  = 3'd0;
	localparam logic [SPK_CFG_IDX_W-1:0] REG_KEY_WORD1  = 3'd1;
	localparam logic [SPK_CFG_IDX_W-1:0] REG_KEY_WORD2  = 3'd2;
	localparam logic [SPK_CFG_IDX_W-1:0] REG_KEY_WORD3  = 3'd3;
	localparam logic [SPK_CFG_IDX_W-1:0] REG_KEY_COUNT  = 3'd4;
	localparam logic [SPK_CFG_IDX_W-1:0] REG_ROUND_COUNT = 3'd5;

	typedef logic [SPK_WORD_W-1:0] word_t;

	typedef struct packed {
		logic fwd;
		logic bwd;
	} ring_ctl_t;

	typedef enum logic [1:0] {
		ST_EXPAND,
		ST_IDLE,
		ST_RUN,
		ST_DONE
	} state_t;

	function automatic word_t ror7(input word_t v);
		return {v[6:0], v[15:7]};
	endfunction

	function automatic word_t rol7(input word_t v);
		return {v[8:0], v[15:9]};
	endfunction

	function automatic word_t ror2(input word_t v);
		return {v[1:0], v[15:2]};
	endfunction

	function automatic word_t rol2(input word_t v);
		return {v[13:0], v[15:14]};
	endfunction

endpackage

>>> rtl/spk_key_cell.sv
// ----------------------------------------------------------------------------
// spk_key_cell
// One round-key cell of the key ring; shifts either way around the ring.
// ----------------------------------------------------------------------------
module spk_key_cell
	import spk_pkg::*;
(
	input  logic      clk,
	input  ring_ctl_t ctl,
	input  word_t     fwd_in,
	input  word_t     bwd_in,
	output word_t     key
);

	word_t key_q;

	always_ff @(posedge clk) begin
		if (ctl.fwd) begin
			key_q <= fwd_in;
		end else if (ctl.bwd) begin
			key_q <= bwd_in;
		end
	end

	assign key = key_q;

endmodule

>>> rtl/spk_key_sched.sv
// ----------------------------------------------------------------------------
// spk_key_sched
// Speck key schedule, one round key per step.
// ----------------------------------------------------------------------------
module spk_key_sched
	import spk_pkg::*;
(
	input  logic                        clk,
	input  logic                        step,
	input  logic                        start,
	input  word_t [SPK_KEY_WORDS-1:0]   key_words,
	input  logic [2:0]                  key_count,
	input  word_t                       iter,
	output word_t                       key_out
);

	word_t       k_q;
	word_t [2:0] l_q;
	word_t       l_new;
	word_t       k_new;

	assign l_new = (ror7(l_q[0]) + k_q) ^ iter;
	assign k_new = rol2(k_q) ^ l_new;
	assign key_out = start ? key_words[0] : k_new;

	// l words take turns: rotate the queue over the words in use
	always_ff @(posedge clk) begin
		if (step) begin
			if (start) begin
				k_q    <= key_words[0];
				l_q[0] <= key_words[1];
				l_q[1] <= key_words[2];
				l_q[2] <= key_words[3];
			end else begin
				k_q <= k_new;
				case (key_count)
					3'd0, 3'd1, 3'd2: begin
						l_q[0] <= l_new;
					end
					3'd3: begin
						l_q[0] <= l_q[1];
						l_q[1] <= l_new;
					end
					default: begin
						l_q[0] <= l_q[1];
						l_q[1] <= l_q[2];
						l_q[2] <= l_new;
					end
				endcase
			end
		end
	end

endmodule

>>> rtl/spk_round_unit.sv
// ----------------------------------------------------------------------------
// spk_round_unit
// Block state register with one forward or inverse Speck round per cycle while en is high.
// ----------------------------------------------------------------------------
module spk_round_unit
	import spk_pkg::*;
(
	input  logic  clk,
	input  logic  load,
	input  word_t load_x,
	input  word_t load_y,
	input  logic  en,
	input  logic  mode,
	input  word_t key,
	output word_t x,
	output word_t y
);

	word_t x_q;
	word_t y_q;
	word_t fx;
	word_t fy;
	word_t ix;
	word_t iy;

	assign fx = (ror7(x_q) + y_q) ^ key;
	assign fy = rol2(y_q) ^ fx;
	assign iy = ror2(y_q ^ x_q);
	assign ix = rol7((x_q ^ key) - iy);

	always_ff @(posedge clk) begin
		if (load) begin
			x_q <= load_x;
			y_q <= load_y;
		end else if (en) begin
			x_q <= mode ? ix : fx;
			y_q <= mode ? iy : fy;
		end
	end

	assign x = x_q;
	assign y = y_q;

endmodule

>>> rtl/speck32_block_cipher.sv
// ----------------------------------------------------------------------------
// speck32_block_cipher
// Speck 32/64 block cipher with a ring of round-key cells.
// ----------------------------------------------------------------------------
// Input transaction on s_*: tdata = {in_y, in_x}, tuser = mode (1 decrypt).
// Output transaction on m_*: tdata = {out_y, out_x}.
// Configuration: cfg_we with cfg_index 0..3 key words, 4 key count,
// 5 round count; any write to 0..5 restarts the key expansion.
// Round keys sit in a ring of MAX_ROUNDS cells. Every pass rotates the
// ring once around, one cell per cycle, forward for encryption and
// backward for decryption. On the steps that the round count selects, the
// block state takes one round per cycle from cell 0 when encrypting or
// from the last cell when decrypting.
// A new block is accepted only in idle: each block makes a full ring
// pass, hands off its result and goes back to idle, whatever the round
// count. Key expansion after reset or a configuration write refills all
// MAX_ROUNDS cells; s_tready stays low meanwhile.
// A finished result waits in the output register; the next block is
// accepted while it waits, and its own result holds until m_tready.
// ----------------------------------------------------------------------------
`include "speck32_block_cipher_assert.svh"

module speck32_block_cipher
	import spk_pkg::*;
#(
	parameter int MAX_ROUNDS = SPK_MAX_ROUNDS
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     s_tvalid,
	output logic                     s_tready,
	input  logic [31:0]              s_tdata,   // in_x [15:0], in_y [31:16]
	input  logic                     s_tuser,   // mode
	output logic                     m_tvalid,
	input  logic                     m_tready,
	output logic [31:0]              m_tdata,   // out_x [15:0], out_y [31:16]
	input  logic                     cfg_we,
	input  logic [SPK_CFG_IDX_W-1:0] cfg_index,
	input  logic [SPK_WORD_W-1:0]    cfg_data
);

	localparam int CNT_W = $clog2(MAX_ROUNDS + 1);
	localparam logic [CNT_W-1:0] LAST = CNT_W'(MAX_ROUNDS - 1);
	localparam logic [CNT_W-1:0] DEF_R = (SPK_DEFAULT_ROUNDS > MAX_ROUNDS) ?
		CNT_W'(MAX_ROUNDS) : CNT_W'(SPK_DEFAULT_ROUNDS);

	word_t [SPK_KEY_WORDS-1:0] kw_q;
	logic [2:0]                key_count_q;
	logic [5:0]                round_count_q;

	state_t           state_q, state_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic             mode_q;
	logic             out_valid_q;
	word_t            out_x_q, out_y_q;

	ring_ctl_t         ctl;
	word_t             ring_key [MAX_ROUNDS];
	word_t             sched_key;
	word_t             tap_key;
	logic              sched_step;
	logic              rnd_en;
	logic              out_load;
	logic              cfg_hit;
	logic              s_accept;
	logic              apply;
	logic [CNT_W-1:0]  r_used;
	logic [6:0]        rc_ext;
	word_t             rx, ry;

	assign cfg_hit  = cfg_we && (cfg_index <= REG_ROUND_COUNT);
	assign s_tready = (state_q == ST_IDLE);
	assign s_accept = s_tvalid && s_tready;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kw_q          <= '0;
			key_count_q   <= 3'd4;
			round_count_q <= 6'(SPK_DEFAULT_ROUNDS);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_KEY_WORD0:   kw_q[0] <= cfg_data;
				REG_KEY_WORD1:   kw_q[1] <= cfg_data;
				REG_KEY_WORD2:   kw_q[2] <= cfg_data;
				REG_KEY_WORD3:   kw_q[3] <= cfg_data;
				REG_KEY_COUNT:   key_count_q <= cfg_data[2:0];
				REG_ROUND_COUNT: round_count_q <= cfg_data[5:0];
				default: ;
			endcase
		end
	end

	// effective round count
	assign rc_ext = {1'b0, round_count_q};
	always_comb begin
		if (round_count_q == '0) begin
			r_used = DEF_R;
		end else if (rc_ext > 7'(MAX_ROUNDS)) begin
			r_used = CNT_W'(MAX_ROUNDS);
		end else begin
			r_used = CNT_W'(rc_ext);
		end
	end

	// encrypt uses the first r steps, decrypt the last r steps of the pass
	assign apply = mode_q ?
		(({1'b0, cnt_q} + {1'b0, r_used}) >= (CNT_W + 1)'(MAX_ROUNDS)) :
		(cnt_q < r_used);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_EXPAND;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		cnt_d      = cnt_q;
		ctl        = '0;
		sched_step = 1'b0;
		rnd_en     = 1'b0;
		out_load   = 1'b0;
		unique case (state_q)
			ST_EXPAND: begin
				ctl.fwd    = 1'b1;
				sched_step = 1'b1;
				if (cnt_q == LAST) begin
					state_d = ST_IDLE;
					cnt_d   = '0;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			ST_IDLE: begin
				if (s_accept) begin
					state_d = ST_RUN;
					cnt_d   = '0;
				end
			end
			ST_RUN: begin
				ctl.fwd = !mode_q;
				ctl.bwd = mode_q;
				rnd_en  = apply;
				if (cnt_q == LAST) begin
					state_d = ST_DONE;
					cnt_d   = '0;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			ST_DONE: begin
				if (!out_valid_q || m_tready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_EXPAND;
				cnt_d   = '0;
			end
		endcase
		if (cfg_hit) begin
			state_d = ST_EXPAND;
			cnt_d   = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			mode_q <= s_tuser;
		end
	end

	spk_key_sched u_sched (
		.clk       (clk),
		.step      (sched_step),
		.start     (cnt_q == '0),
		.key_words (kw_q),
		.key_count (key_count_q),
		.iter      (word_t'(cnt_q) - 16'd1),
		.key_out   (sched_key)
	);

	// key ring; expansion pushes keys in at the tail
	for (genvar j = 0; j < MAX_ROUNDS; j++) begin : g_ring
		localparam int NXT = (j + 1) % MAX_ROUNDS;
		localparam int PRV = (j + MAX_ROUNDS - 1) % MAX_ROUNDS;
		word_t fwd_in;
		if (j == MAX_ROUNDS - 1) begin : g_tail
			assign fwd_in = (state_q == ST_EXPAND) ? sched_key : ring_key[NXT];
		end else begin : g_body
			assign fwd_in = ring_key[NXT];
		end
		spk_key_cell u_cell (
			.clk    (clk),
			.ctl    (ctl),
			.fwd_in (fwd_in),
			.bwd_in (ring_key[PRV]),
			.key    (ring_key[j])
		);
	end

	assign tap_key = mode_q ? ring_key[MAX_ROUNDS-1] : ring_key[0];

	spk_round_unit u_round (
		.clk    (clk),
		.load   (s_accept),
		.load_x (s_tdata[15:0]),
		.load_y (s_tdata[31:16]),
		.en     (rnd_en),
		.mode   (mode_q),
		.key    (tap_key),
		.x      (rx),
		.y      (ry)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_x_q <= rx;
			out_y_q <= ry;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_y_q, out_x_q};

	`ASSERT_NEXT(a_cfg_expand, clk, arst_n, cfg_hit, state_q == ST_EXPAND && cnt_q == '0)
	`ASSERT_NEXT(a_accept_run, clk, arst_n, s_accept && !cfg_hit, state_q == ST_RUN && cnt_q == '0)
	`ASSERT_NEXT(a_done_out, clk, arst_n, out_load && !cfg_hit, out_valid_q && state_q == ST_IDLE)
	`ASSERT_IMPLY(a_ring_dir, clk, arst_n, ctl.bwd, !ctl.fwd && state_q == ST_RUN)

endmodule
